/* src/sprite_blitter_clip_blend_scale_unit_defines.svh */
// assertion macros for the blitter top module
`ifndef SPRITE_BLITTER_CLIP_BLEND_SCALE_UNIT_DEFINES_SVH
`define SPRITE_BLITTER_CLIP_BLEND_SCALE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SBCB_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SBCB_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/sbcb_pkg.sv */
package sbcb_pkg;

	// fixed field widths
	localparam int COL_W  = 11;
	localparam int STEP_W = 24;
	localparam int SPW_W  = 11;
	localparam int SCR_W  = 12;
	localparam int POS_W  = 12;
	localparam int ADDR_W = 22;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	// draw modes
	typedef enum logic [1:0] {
		MODE_KEY_COPY    = 2'd0,
		MODE_ADD         = 2'd1,
		MODE_SCALED_COPY = 2'd2,
		MODE_SCALED_ADD  = 2'd3
	} mode_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POS_X         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POS_Y         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X        = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y        = 3'd7;

	// register reset values
	localparam logic [SPW_W-1:0]  RST_SPRITE_WIDTH  = 11'd1;
	localparam logic [SCR_W-1:0]  RST_SCREEN_WIDTH  = 12'd1024;
	localparam logic [SCR_W-1:0]  RST_SCREEN_HEIGHT = 12'd768;
	localparam logic [STEP_W-1:0] RST_STEP          = 24'd65536;

	// color constants
	localparam logic [7:0] KEY_ALPHA_MAX = 8'd127;
	localparam logic [7:0] CHAN_MAX      = 8'd255;

	// per-transaction control and payload carried down the pipeline
	typedef struct packed {
		logic              is_draw;
		logic              wr_ok;
		logic              pass;
		logic [15:0]       load_index;
		logic [31:0]       load_pixel;
		logic [7:0]        fb_red;
		logic [7:0]        fb_green;
		logic [7:0]        fb_blue;
		logic [SCR_W-1:0]  x;
		logic [SCR_W-1:0]  y;
		logic [ADDR_W-1:0] pixel_addr;
	} meta_t;

	// one result transaction
	typedef struct packed {
		logic              write_en;
		logic [ADDR_W-1:0] pixel_addr;
		logic [7:0]        red;
		logic [7:0]        green;
		logic [7:0]        blue;
	} res_t;

	// stage enables of the index reducer
	typedef struct packed {
		logic s4;
		logic s5;
	} red_en_t;

endpackage

/* src/sprite_blitter_clip_blend_scale_unit.sv */
// Sprite blitter with clip, color key, additive blend and nearest-neighbor scaling.
// Input channel (in_valid / in_stall): cmd 0 loads one BGRA pixel into the sprite
// store at load_index, cmd 1 draws one pixel at (pos_x+col, pos_y+row) using the
// framebuffer color fb_*. Every transaction gives exactly one result transaction on
// the output channel (out_valid / out_stall): write_en, pixel_addr and the new RGB,
// all zero for loads and for clipped or keyed-out draws.
// Registers are written through cfg_we / cfg_index / cfg_data; the user must write them
// only while the block is idle, which the block does not enforce. Throughput is one
// transaction per clock unless the receiver stalls: the sprite store has one read and
// one write port and every transaction touches it exactly once, in order, in stage 5.
// Stages: clip, scale multiply, source index and address multiply, two-step index
// reduction, store access, blend into the output register.
// When the receiver stalls, the pipeline fills up its bubbles first; in_stall rises
// only when all seven stages hold a transaction.
// Reset clears the pipeline and sets the registers to their defaults; the sprite
// store is not cleared and is undefined until loaded.
`include "sprite_blitter_clip_blend_scale_unit_defines.svh"

module sprite_blitter_clip_blend_scale_unit #(
	parameter int SPRITE_PIXELS = 65536,
	parameter int FRAC_BITS     = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [15:0] load_index,
	input  logic [7:0]  load_blue,
	input  logic [7:0]  load_green,
	input  logic [7:0]  load_red,
	input  logic [7:0]  load_alpha,
	input  logic [10:0] col,
	input  logic [10:0] row,
	input  logic [7:0]  fb_red,
	input  logic [7:0]  fb_green,
	input  logic [7:0]  fb_blue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        write_en,
	output logic [21:0] pixel_addr,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue
);

	localparam int AW  = $clog2(SPRITE_PIXELS);
	localparam int PW  = sbcb_pkg::COL_W + sbcb_pkg::STEP_W;
	localparam int SXW = PW - FRAC_BITS;
	localparam int VW  = SXW + sbcb_pkg::SPW_W + 1;
	localparam int SW  = sbcb_pkg::SCR_W;

	// configuration registers
	sbcb_pkg::mode_t                    draw_mode_q;
	logic signed [sbcb_pkg::POS_W-1:0]  pos_x_q;
	logic signed [sbcb_pkg::POS_W-1:0]  pos_y_q;
	logic [sbcb_pkg::SPW_W-1:0]         sprite_width_q;
	logic [SW-1:0]                      screen_width_q;
	logic [SW-1:0]                      screen_height_q;
	logic [sbcb_pkg::STEP_W-1:0]        step_x_q;
	logic [sbcb_pkg::STEP_W-1:0]        step_y_q;

	// pipeline control
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, out_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_out;

	// pipeline payload
	sbcb_pkg::meta_t meta_in, meta_addr;
	sbcb_pkg::meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;
	logic [sbcb_pkg::COL_W-1:0] col_s1, row_s1;
	logic [SXW-1:0]             sx_s2, sy_s2;
	logic [VW-1:0]              v_s3;
	logic [31:0]                pix_s6;
	sbcb_pkg::res_t             res;
	sbcb_pkg::res_t             out_q;

	logic signed [SW:0]  x_sum, y_sum;
	logic                pass_x, pass_y, scaled;
	logic [PW-1:0]       sx_prod, sy_prod;
	logic [2*SW-1:0]     addr_full;
	logic [AW-1:0]       src_idx;
	logic                ram_we;
	sbcb_pkg::red_en_t   red_en;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_mode_q     <= sbcb_pkg::MODE_KEY_COPY;
			pos_x_q         <= '0;
			pos_y_q         <= '0;
			sprite_width_q  <= sbcb_pkg::RST_SPRITE_WIDTH;
			screen_width_q  <= sbcb_pkg::RST_SCREEN_WIDTH;
			screen_height_q <= sbcb_pkg::RST_SCREEN_HEIGHT;
			step_x_q        <= sbcb_pkg::RST_STEP;
			step_y_q        <= sbcb_pkg::RST_STEP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbcb_pkg::REG_DRAW_MODE:     draw_mode_q     <= sbcb_pkg::mode_t'(cfg_data[1:0]);
				sbcb_pkg::REG_POS_X:         pos_x_q         <= cfg_data[11:0];
				sbcb_pkg::REG_POS_Y:         pos_y_q         <= cfg_data[11:0];
				sbcb_pkg::REG_SPRITE_WIDTH:  sprite_width_q  <= cfg_data[10:0];
				sbcb_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[11:0];
				sbcb_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[11:0];
				sbcb_pkg::REG_STEP_X:        step_x_q        <= cfg_data;
				sbcb_pkg::REG_STEP_Y:        step_y_q        <= cfg_data;
			endcase
		end
	end

	// backpressure chain, a stage loads when empty or draining
	assign rdy_out = !out_valid_q || !out_stall;
	assign rdy_s6  = !valid_s6 || rdy_out;
	assign rdy_s5  = !valid_s5 || rdy_s6;
	assign rdy_s4  = !valid_s4 || rdy_s5;
	assign rdy_s3  = !valid_s3 || rdy_s4;
	assign rdy_s2  = !valid_s2 || rdy_s3;
	assign rdy_s1  = !valid_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  valid_s1    <= in_valid;
			if (rdy_s2)  valid_s2    <= valid_s1;
			if (rdy_s3)  valid_s3    <= valid_s2;
			if (rdy_s4)  valid_s4    <= valid_s3;
			if (rdy_s5)  valid_s5    <= valid_s4;
			if (rdy_s6)  valid_s6    <= valid_s5;
			if (rdy_out) out_valid_q <= valid_s6;
		end
	end

	// clip at the input: 0 < x < screen_width, 0 < y < screen_height
	assign x_sum  = $signed({pos_x_q[sbcb_pkg::POS_W-1], pos_x_q}) + $signed({2'b00, col});
	assign y_sum  = $signed({pos_y_q[sbcb_pkg::POS_W-1], pos_y_q}) + $signed({2'b00, row});
	assign pass_x = !x_sum[SW] && (x_sum[SW-1:0] != '0) && (x_sum[SW-1:0] < screen_width_q);
	assign pass_y = !y_sum[SW] && (y_sum[SW-1:0] != '0) && (y_sum[SW-1:0] < screen_height_q);

	always_comb begin
		meta_in            = '0;
		meta_in.is_draw    = (cmd == sbcb_pkg::CMD_DRAW);
		meta_in.wr_ok      = (32'(load_index) < 32'(SPRITE_PIXELS));
		meta_in.pass       = (cmd == sbcb_pkg::CMD_DRAW) && pass_x && pass_y;
		meta_in.load_index = load_index;
		meta_in.load_pixel = {load_alpha, load_red, load_green, load_blue};
		meta_in.fb_red     = fb_red;
		meta_in.fb_green   = fb_green;
		meta_in.fb_blue    = fb_blue;
		meta_in.x          = x_sum[SW-1:0];
		meta_in.y          = y_sum[SW-1:0];
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			meta_s1 <= meta_in;
			col_s1  <= col;
			row_s1  <= row;
		end
	end

	// stage 2: source column and row, scaled by 8.FRAC_BITS steps in the scaled modes
	assign scaled  = (draw_mode_q == sbcb_pkg::MODE_SCALED_COPY) ||
	                 (draw_mode_q == sbcb_pkg::MODE_SCALED_ADD);
	assign sx_prod = PW'(col_s1) * PW'(step_x_q);
	assign sy_prod = PW'(row_s1) * PW'(step_y_q);

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			meta_s2 <= meta_s1;
			sx_s2   <= scaled ? sx_prod[PW-1:FRAC_BITS] : SXW'(col_s1);
			sy_s2   <= scaled ? sy_prod[PW-1:FRAC_BITS] : SXW'(row_s1);
		end
	end

	// stage 3: linear source index and framebuffer address
	assign addr_full = (2*SW)'(meta_s2.y) * (2*SW)'(screen_width_q) + (2*SW)'(meta_s2.x);

	always_comb begin
		meta_addr            = meta_s2;
		meta_addr.pixel_addr = addr_full[sbcb_pkg::ADDR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			meta_s3 <= meta_addr;
			v_s3    <= VW'(sy_s2) * VW'(sprite_width_q) + VW'(sx_s2);
		end
	end

	// stages 4 and 5: index modulo store depth
	assign red_en.s4 = rdy_s4;
	assign red_en.s5 = rdy_s5;

	sbcb_modred #(
		.VW    (VW),
		.DEPTH (SPRITE_PIXELS)
	) u_modred (
		.clk (clk),
		.en  (red_en),
		.v   (v_s3),
		.idx (src_idx)
	);

	always_ff @(posedge clk) begin
		if (rdy_s4) meta_s4 <= meta_s3;
		if (rdy_s5) meta_s5 <= meta_s4;
		if (rdy_s6) meta_s6 <= meta_s5;
	end

	// stage 5 to 6: store access, loads write and every transaction reads
	assign ram_we = rdy_s6 && valid_s5 && !meta_s5.is_draw && meta_s5.wr_ok;

	sbcb_ram #(
		.WIDTH (32),
		.DEPTH (SPRITE_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(meta_s5.load_index)),
		.wdata (meta_s5.load_pixel),
		.re    (rdy_s6),
		.raddr (src_idx),
		.rdata (pix_s6)
	);

	// stage 6: key and blend into the output register
	sbcb_blend u_blend (
		.mode (draw_mode_q),
		.meta (meta_s6),
		.pix  (pix_s6),
		.res  (res)
	);

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign write_en   = out_q.write_en;
	assign pixel_addr = out_q.pixel_addr;
	assign out_red    = out_q.red;
	assign out_green  = out_q.green;
	assign out_blue   = out_q.blue;

	// input stalls only with every stage occupied and the receiver stalling
	`SBCB_CHECK(a_stall_only_full, in_stall, valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && valid_s6 && out_valid_q && out_stall, "input stalled with a bubble in the pipeline")
	// a result without write carries zero payload
	`SBCB_CHECK(a_nowrite_zero, out_valid_q && !out_q.write_en, (out_q.pixel_addr == '0) && (out_q.red == '0) && (out_q.green == '0) && (out_q.blue == '0), "non-writing result with nonzero payload")
	// loads and clipped draws leave without a write
	`SBCB_CHECK_NEXT(a_clipped_nowrite, rdy_out && valid_s6 && !meta_s6.pass, out_valid_q && !out_q.write_en, "clipped draw or load produced a write")

endmodule

/* src/sbcb_ram.sv */
module sbcb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port, read returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/sbcb_modred.sv */
module sbcb_modred #(
	parameter int VW    = 31,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  sbcb_pkg::red_en_t        en,
	input  logic [VW-1:0]            v,
	output logic [$clog2(DEPTH)-1:0] idx
);

	localparam int AW = $clog2(DEPTH);
	localparam int MW = VW - AW + 1;
	localparam logic [MW-1:0] BAR_M = MW'((64'd1 << VW) / DEPTH);
	localparam logic [AW:0] DEPTH_LO = (AW+1)'(DEPTH);

	logic [VW+MW-1:0] prod;
	logic [MW-1:0]    qe_s4;
	logic [AW:0]      vlo_s4;
	logic [AW:0]      qc_lo;
	logic [AW:0]      r_s5;

	// quotient estimate, at most one below the true quotient
	assign prod = (VW+MW)'(v) * (VW+MW)'(BAR_M);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			qe_s4  <= prod[VW+MW-1:VW];
			vlo_s4 <= v[AW:0];
		end
	end

	// remainder estimate below twice the depth, only low bits matter
	assign qc_lo = (AW+1)'(qe_s4) * DEPTH_LO;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			r_s5 <= vlo_s4 - qc_lo;
		end
	end

	// final correction
	assign idx = (r_s5 >= DEPTH_LO) ? AW'(r_s5 - DEPTH_LO) : r_s5[AW-1:0];

endmodule

/* src/sbcb_blend.sv */
module sbcb_blend (
	input  sbcb_pkg::mode_t mode,
	input  sbcb_pkg::meta_t meta,
	input  logic [31:0]     pix,
	output sbcb_pkg::res_t  res
);

	logic [7:0] src_red;
	logic [7:0] src_green;
	logic [7:0] src_blue;
	logic [7:0] src_alpha;
	logic [8:0] sum_red;
	logic [8:0] sum_green;
	logic [8:0] sum_blue;
	logic       additive;
	logic       keyed_out;

	assign src_blue  = pix[7:0];
	assign src_green = pix[15:8];
	assign src_red   = pix[23:16];
	assign src_alpha = pix[31:24];

	assign additive  = (mode == sbcb_pkg::MODE_ADD) || (mode == sbcb_pkg::MODE_SCALED_ADD);
	assign keyed_out = (mode == sbcb_pkg::MODE_KEY_COPY) && (src_alpha <= sbcb_pkg::KEY_ALPHA_MAX);

	// per-channel sums with carry for saturation
	assign sum_red   = {1'b0, meta.fb_red} + {1'b0, src_red};
	assign sum_green = {1'b0, meta.fb_green} + {1'b0, src_green};
	assign sum_blue  = {1'b0, meta.fb_blue} + {1'b0, src_blue};

	// result: zeros unless a draw passes clip and key
	always_comb begin
		res = '0;
		if (meta.pass && !keyed_out) begin
			res.write_en   = 1'b1;
			res.pixel_addr = meta.pixel_addr;
			if (additive) begin
				res.red   = sum_red[8] ? sbcb_pkg::CHAN_MAX : sum_red[7:0];
				res.green = sum_green[8] ? sbcb_pkg::CHAN_MAX : sum_green[7:0];
				res.blue  = sum_blue[8] ? sbcb_pkg::CHAN_MAX : sum_blue[7:0];
			end else begin
				res.red   = src_red;
				res.green = src_green;
				res.blue  = src_blue;
			end
		end
	end

endmodule

/* dv/sprite_blitter_clip_blend_scale_unit_test.sv */
`timescale 1ns / 100ps

module sprite_blitter_clip_blend_scale_unit_test;
	import sbcb_pkg::*;

	localparam int SPRITE_PIXELS = 65536;
	localparam int FRAC_BITS     = 16;
	localparam int QUIET_LIMIT   = 4000;
	localparam int PHASE_ITEMS   = 45;
	localparam int NUM_PHASES    = 8;

	// one input transaction
	typedef struct {
		logic        cmd;
		logic [15:0] load_index;
		logic [7:0]  load_blue;
		logic [7:0]  load_green;
		logic [7:0]  load_red;
		logic [7:0]  load_alpha;
		logic [10:0] col;
		logic [10:0] row;
		logic [7:0]  fb_red;
		logic [7:0]  fb_green;
		logic [7:0]  fb_blue;
	} blit_txn_t;

	// register file contents
	typedef struct {
		mode_t              mode;
		logic signed [11:0] pos_x;
		logic signed [11:0] pos_y;
		logic [10:0]        sprite_width;
		logic [11:0]        screen_width;
		logic [11:0]        screen_height;
		logic [23:0]        step_x;
		logic [23:0]        step_y;
	} cfg_t;

	// pixel predictor and in-order result checker
	class blit_scoreboard;
		cfg_t        cfg;
		logic [31:0] sprite_mem [SPRITE_PIXELS];
		res_t        expected_px [$];
		int          errors;
		int          n_loads;
		int          n_draws;
		int          n_writes;
		int          n_checked;

		function new();
			cfg.mode          = MODE_KEY_COPY;
			cfg.pos_x         = '0;
			cfg.pos_y         = '0;
			cfg.sprite_width  = RST_SPRITE_WIDTH;
			cfg.screen_width  = RST_SCREEN_WIDTH;
			cfg.screen_height = RST_SCREEN_HEIGHT;
			cfg.step_x        = RST_STEP;
			cfg.step_y        = RST_STEP;
			errors = 0;
			n_loads = 0;
			n_draws = 0;
			n_writes = 0;
			n_checked = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [23:0] d);
			case (idx)
				REG_DRAW_MODE:     cfg.mode = mode_t'(d[1:0]);
				REG_POS_X:         cfg.pos_x = d[11:0];
				REG_POS_Y:         cfg.pos_y = d[11:0];
				REG_SPRITE_WIDTH:  cfg.sprite_width = d[10:0];
				REG_SCREEN_WIDTH:  cfg.screen_width = d[11:0];
				REG_SCREEN_HEIGHT: cfg.screen_height = d[11:0];
				REG_STEP_X:        cfg.step_x = d;
				REG_STEP_Y:        cfg.step_y = d;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_px.size();
		endfunction

		// clip test plus nearest source pixel; 1 when the draw reaches the store
		function bit source_pixel(input logic [10:0] c, input logic [10:0] r,
				output logic [15:0] idx, output int x, output int y);
			longint unsigned sx;
			longint unsigned sy;
			idx = '0;
			x = int'(cfg.pos_x) + int'(c);
			y = int'(cfg.pos_y) + int'(r);
			if (x <= 0 || y <= 0 || x >= int'(cfg.screen_width) ||
					y >= int'(cfg.screen_height))
				return 1'b0;
			if (cfg.mode == MODE_SCALED_COPY || cfg.mode == MODE_SCALED_ADD) begin
				sx = (64'(c) * 64'(cfg.step_x)) >> FRAC_BITS;
				sy = (64'(r) * 64'(cfg.step_y)) >> FRAC_BITS;
			end else begin
				sx = 64'(c);
				sy = 64'(r);
			end
			idx = 16'((sy * 64'(cfg.sprite_width) + sx) % 64'(SPRITE_PIXELS));
			return 1'b1;
		endfunction

		function logic [7:0] sat_add8(logic [7:0] a, logic [7:0] b);
			logic [8:0] s;
			s = {1'b0, a} + {1'b0, b};
			return (s > {1'b0, CHAN_MAX}) ? CHAN_MAX : s[7:0];
		endfunction

		// work out the result of one accepted transaction
		function void note_input(blit_txn_t t);
			res_t        r;
			logic [15:0] idx;
			logic [31:0] pix;
			int          x;
			int          y;
			r = '0;
			if (t.cmd == CMD_LOAD) begin
				n_loads++;
				if (int'(t.load_index) < SPRITE_PIXELS)
					sprite_mem[t.load_index] = {t.load_alpha, t.load_red,
						t.load_green, t.load_blue};
			end else begin
				n_draws++;
				if (source_pixel(t.col, t.row, idx, x, y)) begin
					pix = sprite_mem[idx];
					// keyed copy drops pixels with alpha at or below the key
					if (!(cfg.mode == MODE_KEY_COPY && pix[31:24] <= KEY_ALPHA_MAX)) begin
						n_writes++;
						r.write_en   = 1'b1;
						r.pixel_addr = 22'(longint'(y) * longint'(cfg.screen_width) +
							longint'(x));
						if (cfg.mode == MODE_ADD || cfg.mode == MODE_SCALED_ADD) begin
							r.red   = sat_add8(t.fb_red, pix[23:16]);
							r.green = sat_add8(t.fb_green, pix[15:8]);
							r.blue  = sat_add8(t.fb_blue, pix[7:0]);
						end else begin
							r.red   = pix[23:16];
							r.green = pix[15:8];
							r.blue  = pix[7:0];
						end
					end
				end
			end
			expected_px.push_back(r);
		endfunction

		task report(string what);
			errors++;
			if (errors <= 20)
				$display("mismatch at %0t ns: %s", $time, what);
		endtask

		// compare one result transaction against the oldest prediction
		task check_result(res_t got);
			res_t exp_r;
			if (expected_px.size() == 0) begin
				report("result transaction with nothing expected");
				return;
			end
			exp_r = expected_px.pop_front();
			n_checked++;
			if (got.write_en !== exp_r.write_en)
				report($sformatf("result %0d write_en %b, expected %b", n_checked,
					got.write_en, exp_r.write_en));
			if (got.pixel_addr !== exp_r.pixel_addr)
				report($sformatf("result %0d pixel_addr %0h, expected %0h", n_checked,
					got.pixel_addr, exp_r.pixel_addr));
			if (got.red !== exp_r.red)
				report($sformatf("result %0d out_red %0h, expected %0h", n_checked,
					got.red, exp_r.red));
			if (got.green !== exp_r.green)
				report($sformatf("result %0d out_green %0h, expected %0h", n_checked,
					got.green, exp_r.green));
			if (got.blue !== exp_r.blue)
				report($sformatf("result %0d out_blue %0h, expected %0h", n_checked,
					got.blue, exp_r.blue));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        cmd = 1'b0;
	logic [15:0] load_index = '0;
	logic [7:0]  load_blue = '0;
	logic [7:0]  load_green = '0;
	logic [7:0]  load_red = '0;
	logic [7:0]  load_alpha = '0;
	logic [10:0] col = '0;
	logic [10:0] row = '0;
	logic [7:0]  fb_red = '0;
	logic [7:0]  fb_green = '0;
	logic [7:0]  fb_blue = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        write_en;
	logic [21:0] pixel_addr;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;

	blit_scoreboard sb;
	bit             loaded [SPRITE_PIXELS];
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	int             n_settings = 0;

	sprite_blitter_clip_blend_scale_unit #(
		.SPRITE_PIXELS(SPRITE_PIXELS),
		.FRAC_BITS(FRAC_BITS)
	) dut (.*);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
	end

	// watch both channels
	always @(posedge clk) begin : monitor
		blit_txn_t t;
		res_t      r;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				t.cmd        = cmd;
				t.load_index = load_index;
				t.load_blue  = load_blue;
				t.load_green = load_green;
				t.load_red   = load_red;
				t.load_alpha = load_alpha;
				t.col        = col;
				t.row        = row;
				t.fb_red     = fb_red;
				t.fb_green   = fb_green;
				t.fb_blue    = fb_blue;
				sb.note_input(t);
			end
			if (out_valid && !out_stall) begin
				r.write_en   = write_en;
				r.pixel_addr = pixel_addr;
				r.red        = out_red;
				r.green      = out_green;
				r.blue       = out_blue;
				sb.check_result(r);
			end
		end
	end

	// end the run when neither channel moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("** sprite_blitter_clip_blend_scale_unit: FAILED **");
		$finish;
	end

	function automatic blit_txn_t random_txn();
		blit_txn_t t;
		t.cmd        = 1'($urandom);
		t.load_index = 16'($urandom);
		t.load_blue  = 8'($urandom);
		t.load_green = 8'($urandom);
		t.load_red   = 8'($urandom);
		t.load_alpha = 8'($urandom);
		t.col        = 11'($urandom);
		t.row        = 11'($urandom);
		t.fb_red     = 8'($urandom);
		t.fb_green   = 8'($urandom);
		t.fb_blue    = 8'($urandom);
		// push the framebuffer color toward saturation now and then
		if ($urandom_range(7) == 0) begin
			t.fb_red   = CHAN_MAX;
			t.fb_green = CHAN_MAX;
			t.fb_blue  = CHAN_MAX;
		end
		return t;
	endfunction

	// offset that lands inside the clip window when one exists
	function automatic logic [10:0] pick_offset(int origin, int limit);
		int lo;
		int hi;
		lo = 1 - origin;
		hi = limit - 1 - origin;
		if (lo < 0)
			lo = 0;
		if (hi > 2047)
			hi = 2047;
		if (lo > hi)
			return 11'($urandom);
		return 11'($urandom_range(hi, lo));
	endfunction

	// one input transaction, with random idle cycles ahead of it
	task automatic send(input blit_txn_t t);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= t.cmd;
		load_index <= t.load_index;
		load_blue  <= t.load_blue;
		load_green <= t.load_green;
		load_red   <= t.load_red;
		load_alpha <= t.load_alpha;
		col        <= t.col;
		row        <= t.row;
		fb_red     <= t.fb_red;
		fb_green   <= t.fb_green;
		fb_blue    <= t.fb_blue;
		if (t.cmd == CMD_LOAD && int'(t.load_index) < SPRITE_PIXELS)
			loaded[t.load_index] = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic load_px(input logic [15:0] idx, input logic [31:0] pix);
		blit_txn_t t;
		t = random_txn();
		t.cmd        = CMD_LOAD;
		t.load_index = idx;
		{t.load_alpha, t.load_red, t.load_green, t.load_blue} = pix;
		send(t);
	endtask

	// a draw, preceded by a load when its source pixel was never written
	task automatic send_draw(input blit_txn_t t);
		logic [15:0] idx;
		int          x;
		int          y;
		t.cmd = CMD_DRAW;
		if (sb.source_pixel(t.col, t.row, idx, x, y) && !loaded[idx])
			load_px(idx, $urandom);
		send(t);
	endtask

	task automatic draw_at(input logic [10:0] c, input logic [10:0] r,
			input logic [23:0] fb);
		blit_txn_t t;
		t = random_txn();
		t.col = c;
		t.row = r;
		{t.fb_red, t.fb_green, t.fb_blue} = fb;
		send_draw(t);
	endtask

	// stop sending until every expected result has come back
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
		repeat (8) @(posedge clk);
	endtask

	// write every register, block idle
	task automatic apply_config(input cfg_t c);
		logic [23:0] d;
		int          i;
		for (i = 0; i < 8; i++) begin
			case (3'(i))
				REG_DRAW_MODE:     d = 24'(c.mode);
				REG_POS_X:         d = 24'(c.pos_x);
				REG_POS_Y:         d = 24'(c.pos_y);
				REG_SPRITE_WIDTH:  d = 24'(c.sprite_width);
				REG_SCREEN_WIDTH:  d = 24'(c.screen_width);
				REG_SCREEN_HEIGHT: d = 24'(c.screen_height);
				REG_STEP_X:        d = c.step_x;
				default:           d = c.step_y;
			endcase
			cfg_we    <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= d;
			sb.set_reg(3'(i), d);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// mostly in-window draws, plus random loads and out-of-window noise
	task automatic random_item();
		blit_txn_t t;
		t = random_txn();
		if ($urandom_range(99) < 25) begin
			t.cmd = CMD_LOAD;
			send(t);
		end else begin
			if ($urandom_range(99) < 85) begin
				t.col = pick_offset(int'(sb.cfg.pos_x), int'(sb.cfg.screen_width));
				t.row = pick_offset(int'(sb.cfg.pos_y), int'(sb.cfg.screen_height));
			end
			send_draw(t);
		end
	endtask

	initial begin
		cfg_t c;
		int   phase;
		int   k;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, clip edges and the alpha key threshold
		c = sb.cfg;
		apply_config(c);
		load_px(16'hFFFF, 32'hFFFF_FFFF);
		load_px(16'h0000, 32'h0000_0000);
		load_px(16'd2, 32'h8011_2233);
		load_px(16'd3, 32'h7F44_5566);
		draw_at(11'd0, 11'd0, 24'h0);
		draw_at(11'd1, 11'd1, 24'h0);
		draw_at(11'd2, 11'd1, 24'h0);
		draw_at(11'd2047, 11'd1, 24'h0);
		draw_at(11'd1, 11'd2047, 24'h0);
		draw_at(11'd1023, 11'd767, 24'h0);

		// additive, saturating and not
		settle();
		c.mode = MODE_ADD;
		apply_config(c);
		draw_at(11'd1, 11'd1, 24'hFFFFFF);
		draw_at(11'd1, 11'd1, 24'h0);

		// scaled copy with full-scale column step, zero row step, zero stride
		settle();
		c.mode         = MODE_SCALED_COPY;
		c.sprite_width = 11'd0;
		c.step_x       = 24'hFFFFFF;
		c.step_y       = 24'h0;
		apply_config(c);
		draw_at(11'd2047, 11'd5, 24'h0);
		draw_at(11'd1, 11'd700, 24'h0);

		// scaled additive with zero steps always reads the first entry
		settle();
		c.mode         = MODE_SCALED_ADD;
		c.sprite_width = 11'h7FF;
		c.step_x       = 24'h0;
		apply_config(c);
		draw_at(11'd3, 11'd3, 24'hFFFFFF);
		draw_at(11'd5, 11'd9, 24'h0);

		// zero screen clips everything
		settle();
		c.screen_width  = 12'd0;
		c.screen_height = 12'd0;
		apply_config(c);
		draw_at(11'd1, 11'd1, 24'h0);

		// origin x at the negative extreme, origin y at the positive extreme
		settle();
		c.screen_width  = 12'hFFF;
		c.screen_height = 12'hFFF;
		c.pos_x         = 12'sh800;
		c.pos_y         = 12'sd2047;
		apply_config(c);
		draw_at(11'd2047, 11'd0, 24'h0);

		// origin at the positive extreme, address wraps to 22 bits
		settle();
		c.mode         = MODE_KEY_COPY;
		c.pos_x        = 12'sd2047;
		c.sprite_width = 11'd1024;
		c.step_x       = RST_STEP;
		c.step_y       = RST_STEP;
		apply_config(c);
		load_px(16'(2047 * 1024 + 2047), 32'hFFAB_CDEF);
		draw_at(11'd2047, 11'd2047, 24'h0);

		// random phases, each with its own settings and flow-control mix
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			send_idle_pct  = 0;
			recv_stall_pct = 0;
			case (phase)
				0: begin
					c.mode = MODE_KEY_COPY;
					c.pos_x = 12'sd0;
					c.pos_y = 12'sd0;
					c.sprite_width = 11'd16;
					c.screen_width = 12'd64;
					c.screen_height = 12'd48;
					c.step_x = RST_STEP;
					c.step_y = RST_STEP;
				end
				1: begin
					c.mode = MODE_ADD;
					c.pos_x = -12'sd5;
					c.pos_y = 12'sd3;
					c.sprite_width = 11'd1024;
					c.screen_width = 12'd2048;
					c.screen_height = 12'd2048;
				end
				2: begin
					c.mode = MODE_SCALED_COPY;
					c.pos_x = 12'sd100;
					c.pos_y = 12'sd7;
					c.sprite_width = 11'd37;
					c.screen_width = 12'd300;
					c.screen_height = 12'd200;
					c.step_x = 24'h008000;
					c.step_y = 24'h018000;
				end
				3: begin
					c.mode = MODE_SCALED_ADD;
					c.pos_x = 12'sd2047;
					c.pos_y = 12'sd2047;
					c.sprite_width = 11'h7FF;
					c.screen_width = 12'hFFF;
					c.screen_height = 12'hFFF;
					c.step_x = 24'hFFFFFF;
					c.step_y = 24'hFFFFFF;
				end
				default: begin
					c.mode = mode_t'(phase - 4);
					c.pos_x = 12'(int'($urandom_range(600)) - 300);
					c.pos_y = 12'(int'($urandom_range(600)) - 300);
					c.sprite_width = 11'($urandom_range(1024, 1));
					c.screen_width = 12'($urandom_range(2048, 2));
					c.screen_height = 12'($urandom_range(2048, 2));
					c.step_x = 24'($urandom_range(24'h040000));
					c.step_y = 24'($urandom_range(24'h040000));
				end
			endcase
			apply_config(c);
			case (phase % 4)
				1: send_idle_pct = 67;
				2: recv_stall_pct = 67;
				3: begin
					send_idle_pct  = 38;
					recv_stall_pct = 38;
				end
				default: ;
			endcase
			for (k = 0; k < PHASE_ITEMS; k++) begin
				random_item();
				if ($urandom_range(59) == 0)
					settle();
			end
		end

		// drain and let the pipeline run dry
		settle();
		repeat (10) @(posedge clk);

		$display("covered %0d loads and %0d draws, %0d of them written, %0d results checked",
			sb.n_loads, sb.n_draws, sb.n_writes, sb.n_checked);
		$display("over %0d register settings in all four modes, with and without stalls",
			n_settings);
		if (sb.errors == 0)
			$display("** sprite_blitter_clip_blend_scale_unit: PASSED **");
		else
			$display("** sprite_blitter_clip_blend_scale_unit: FAILED **");
		$finish;
	end

endmodule
